// ===== src/radix_conversion_to_digits_assert.svh =====
// Assertion macros for the radix conversion block.
`ifndef RADIX_CONVERSION_TO_DIGITS_ASSERT_SVH
`define RADIX_CONVERSION_TO_DIGITS_ASSERT_SVH

`ifndef SYNTH
`define RCD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rcd assertion failed");
`define RCD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rcd assertion failed");
`else
`define RCD_ASSERT(lbl, clk, rstn, prop)
`define RCD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== src/rcd_pkg.sv =====
// Shared types, constants and digit glyph function for the radix converter.
`timescale 1ns / 1ps
`default_nettype none
package rcd_pkg;

  localparam int unsigned VALUE_W = 31;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned STEP_W  = 5;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [STEP_W-1:0]  LAST_STEP = STEP_W'(VALUE_W - 1);

  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h41;
  localparam logic [DIGIT_W-1:0] DEC_LIMIT = 6'd10;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [RADIX_W-1:0] divisor;
  } rcd_div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
  } rcd_div_rsp_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_LIMIT) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else if (d < RADIX_MAX) begin
      c = CHAR_A + CHAR_W'(d - DEC_LIMIT);
    end else begin
      c = '0;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/rcd_div.sv =====
// Bit-serial restoring divider: 31-bit dividend by 6-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "radix_conversion_to_digits_assert.svh"
module rcd_div
  import rcd_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire rcd_div_req_t req_i,
  output rcd_div_rsp_t      rsp_o
);

  logic [VALUE_W-1:0] q_q, q_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] div_q, div_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DIGIT_W:0]   trial;
  logic               ge;

  assign trial = {rem_q, q_q[VALUE_W-1]};
  assign ge    = (trial >= {1'b0, div_q});

  always_comb begin
    q_d    = q_q;
    rem_d  = rem_q;
    div_d  = div_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      q_d    = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      q_d    = {q_q[VALUE_W-2:0], ge};
      rem_d  = ge ? DIGIT_W'(trial - {1'b0, div_q}) : trial[DIGIT_W-1:0];
      step_d = step_q + 1'b1;
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = q_q;
  assign rsp_o.remainder = rem_q;

  `RCD_ASSERT(a_start_idle, clk_i, rst_ni, req_i.start |-> !busy_q)
  `RCD_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q) && !busy_q)
  `RCD_ASSERT(a_divisor_ok, clk_i, rst_ni, busy_q |-> (div_q >= RADIX_MIN) && (div_q <= RADIX_MAX))

endmodule
`default_nettype wire

// ===== src/radix_conversion_to_digits.sv =====
// Radix converter: converts a value into its digits in the given radix.
// Each digit takes a bit-serial division, then is stored and the next division restarts.
// Digits leave most significant first from a registered digit store, as the output allows.
// An invalid value or base yields its single error beat after acceptance.
// One input at a time; the next is accepted once the last digit or error is in the output register.
// rst_ni is asynchronous, active low; it clears control state, the digit store is not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "radix_conversion_to_digits_assert.svh"
module radix_conversion_to_digits
  import rcd_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // [30:0] value, [36:31] radix, rest zero
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // [6:0] char_code, [12:7] digit_value, rest zero
  output logic             m_axis_tlast_o,
  output logic             m_axis_tuser_o   // [0] error
);

  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [AW-1:0] TOP_IDX = AW'(MAX_DIGITS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_ERR  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [RADIX_W-1:0] radix_q, radix_d;

  logic               m_valid_q, m_valid_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic               last_q, last_d;
  logic               err_q, err_d;

  logic [DIGIT_W-1:0] store_q [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data_q;
  logic               wr_en;

  rcd_div_req_t div_req;
  rcd_div_rsp_t div_rsp;

  logic [VALUE_W-1:0] in_value;
  logic [RADIX_W-1:0] in_radix;
  logic               in_bad;
  logic               accept;
  logic               out_free;

  assign in_value = s_axis_tdata_i[VALUE_W-1:0];
  assign in_radix = s_axis_tdata_i[VALUE_W+RADIX_W-1:VALUE_W];
  assign in_bad   = (in_value == '0) || (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  rcd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    radix_d   = radix_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    char_d    = char_q;
    digit_d   = digit_q;
    last_d    = last_q;
    err_d     = err_q;
    wr_en     = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = in_value;
    div_req.divisor  = in_radix;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          radix_d = in_radix;
          idx_d   = '0;
          if (in_bad) begin
            state_d = ST_ERR;
          end else begin
            div_req.start = 1'b1;
            state_d       = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          wr_en = 1'b1;
          if (div_rsp.quotient == '0) begin
            state_d = ST_RD;
          end else if (idx_q == TOP_IDX) begin
            state_d = ST_ERR;
          end else begin
            idx_d            = idx_q + 1'b1;
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quotient;
            div_req.divisor  = radix_q;
          end
        end
      end
      ST_RD: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          digit_d   = rd_data_q;
          char_d    = glyph(rd_data_q);
          last_d    = (idx_q == '0);
          err_d     = 1'b0;
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = ST_RD;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          digit_d   = '0;
          char_d    = '0;
          last_d    = 1'b1;
          err_d     = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q <= radix_d;
    char_q  <= char_d;
    digit_q <= digit_d;
    last_q  <= last_d;
    err_q   <= err_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[idx_q] <= div_rsp.remainder;
    end
    rd_data_q <= store_q[idx_q];
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b000, digit_q, char_q};
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = err_q;

  `RCD_ASSERT(a_err_single, clk_i, rst_ni, m_valid_q && err_q |-> last_q && (digit_q == '0))
  `RCD_ASSERT(a_glyph_match, clk_i, rst_ni, m_valid_q && !err_q |-> char_q == glyph(digit_q))
  `RCD_ASSERT(a_done_in_div, clk_i, rst_ni, div_rsp.done |-> state_q == ST_DIV)
  `RCD_ASSERT(a_div_only_in_div, clk_i, rst_ni, div_rsp.busy |-> state_q == ST_DIV)

endmodule
`default_nettype wire
